FILE: src/mfc_pkg.sv
package mfc_pkg;

   // operation codes carried in the func field
   typedef enum logic [1:0] {
      FUNC_CMD     = 2'd0,
      FUNC_ENABLE  = 2'd1,
      FUNC_DISABLE = 2'd2,
      FUNC_DECODE  = 2'd3
   } func_type;

   // register file layout
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ID   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TQ_LIMIT  = 3'd4;

   localparam int ID_W  = 11;
   localparam int LIM_W = 26;

   localparam logic [ID_W-1:0]  BASE_ID_RST   = 11'd1;
   localparam logic [ID_W-1:0]  ID_OFFSET_RST = 11'd0;
   localparam logic [LIM_W-1:0] POS_LIM_RST   = 26'd819200;
   localparam logic [LIM_W-1:0] VEL_LIM_RST   = 26'd1966080;
   localparam logic [LIM_W-1:0] TQ_LIM_RST    = 26'd655360;

   // gain ranges in Q16.16
   localparam logic [24:0] KP_TOP = 25'd32768000;
   localparam logic [18:0] KD_TOP = 19'd327680;

   // gain scaling: KP_TOP is 125 << 18 and KD_TOP is 5 << 16, so after the
   // power-of-two shift the rest is a multiply by ceil(2^26/125) or ceil(2^17/5)
   localparam logic [19:0] KP_RECIP = 20'd536871;
   localparam logic [14:0] KD_RECIP = 15'd26215;

   // control frames
   localparam logic [63:0] FRAME_FILL   = 64'hFFFF_FFFF_FFFF_FF00;
   localparam logic [7:0]  ENABLE_CODE  = 8'hFC;
   localparam logic [7:0]  DISABLE_CODE = 8'hFD;

   // shared divider geometry
   localparam int DIV_NUM_W = 43;
   localparam int DIV_DEN_W = 27;
   localparam int DIV_QUO_W = 27;

   localparam logic [DIV_DEN_W-1:0] TOP16 = 27'd65535;
   localparam logic [DIV_DEN_W-1:0] TOP12 = 27'd4095;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] pos_cmd;
      logic signed [31:0] vel_cmd;
      logic [30:0]        stiffness_cmd;
      logic [30:0]        damping_cmd;
      logic signed [31:0] torque_cmd;
      logic [63:0]        rx_frame;
   } req_type;

   // what travels beside the dividers
   typedef struct packed {
      func_type    func;
      logic [7:0]  hdr;
      logic [15:0] temps;
      logic [11:0] kp_q;
      logic [11:0] kd_q;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic [26:0] u_pos;
      logic [26:0] u_vel;
      logic [26:0] u_tq;
      logic [18:0] kp_z;
      logic [14:0] kd_z;
      logic [42:0] dq_pos;
      logic [38:0] dq_vel;
      logic [38:0] dq_tq;
   } prep_type;

   typedef struct packed {
      logic        tx_valid;
      logic [10:0] tx_id;
      logic [63:0] tx_data;
      logic [3:0]  fb_motor_id;
      logic [3:0]  fb_state;
      logic [31:0] fb_position;
      logic [31:0] fb_velocity;
      logic [31:0] fb_torque;
      logic [7:0]  mos_temp;
      logic [7:0]  coil_temp;
   } rsp_type;

   function automatic logic [LIM_W-1:0] eff_limit(logic [LIM_W-1:0] lim);
      return (lim == '0) ? LIM_W'(1) : lim;
   endfunction

   // clamp to +/- lim and shift into 0..2*lim
   function automatic logic [LIM_W:0] clamp_offset(logic signed [31:0] x,
                                                   logic [LIM_W-1:0] lim);
      logic signed [32:0] xs;
      logic signed [32:0] ls;
      logic signed [32:0] sum;
      xs  = 33'(x);
      ls  = $signed({7'd0, lim});
      sum = xs + ls;
      if (xs > ls) return {lim, 1'b0};
      else if (xs < -ls) return '0;
      else return sum[LIM_W:0];
   endfunction

endpackage

FILE: src/mfc_req_if.sv
interface mfc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] pos_cmd;
   logic signed [31:0] vel_cmd;
   logic [30:0]        stiffness_cmd;
   logic [30:0]        damping_cmd;
   logic signed [31:0] torque_cmd;
   logic [63:0]        rx_frame;

   modport source (output valid, func, pos_cmd, vel_cmd, stiffness_cmd, damping_cmd,
                   torque_cmd, rx_frame, input ready);
   modport sink (input valid, func, pos_cmd, vel_cmd, stiffness_cmd, damping_cmd,
                 torque_cmd, rx_frame, output ready);
endinterface

FILE: src/mfc_rsp_if.sv
interface mfc_rsp_if;
   logic               valid;
   logic               ready;
   logic               tx_valid;
   logic [10:0]        tx_id;
   logic [63:0]        tx_data;
   logic [3:0]         fb_motor_id;
   logic [3:0]         fb_state;
   logic signed [31:0] fb_position;
   logic signed [31:0] fb_velocity;
   logic signed [31:0] fb_torque;
   logic [7:0]         mos_temp;
   logic [7:0]         coil_temp;

   modport source (output valid, tx_valid, tx_id, tx_data, fb_motor_id, fb_state,
                   fb_position, fb_velocity, fb_torque, mos_temp, coil_temp,
                   input ready);
   modport sink (input valid, tx_valid, tx_id, tx_data, fb_motor_id, fb_state,
                 fb_position, fb_velocity, fb_torque, mos_temp, coil_temp,
                 output ready);
endinterface

FILE: src/mfc_div.sv
module mfc_div #(
   parameter int NumWidth = mfc_pkg::DIV_NUM_W,
   parameter int DenWidth = mfc_pkg::DIV_DEN_W,
   parameter int QuoWidth = mfc_pkg::DIV_QUO_W
) (
   input  logic                clock,
   input  logic                advance,
   input  logic [NumWidth-1:0] num,
   input  logic [DenWidth-1:0] den,
   output logic [QuoWidth-1:0] quo
);

   // one quotient bit per stage, numerator must be below den << QuoWidth
   logic [DenWidth-1:0] rem_ff [QuoWidth];
   logic [QuoWidth-1:0] nlo_ff [QuoWidth];
   logic [QuoWidth-1:0] quo_ff [QuoWidth];
   logic [DenWidth-1:0] den_ff [QuoWidth];

   for (genvar k = 0; k < QuoWidth; k++) begin : g_stage
      logic [DenWidth-1:0] rem_prev;
      logic [QuoWidth-1:0] nlo_prev;
      logic [QuoWidth-1:0] quo_prev;
      logic [DenWidth-1:0] den_prev;
      logic [DenWidth:0]   trial;
      logic [DenWidth:0]   diff;
      logic                ge;
      logic [DenWidth-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev = DenWidth'(num[NumWidth-1:QuoWidth]);
         assign nlo_prev = num[QuoWidth-1:0];
         assign quo_prev = '0;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nlo_prev = nlo_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      // restoring step
      assign trial  = {rem_prev, nlo_prev[QuoWidth-1]};
      assign diff   = trial - {1'b0, den_prev};
      assign ge     = (trial >= {1'b0, den_prev});
      assign rem_in = ge ? diff[DenWidth-1:0] : trial[DenWidth-1:0];

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            nlo_ff[k] <= nlo_prev << 1;
            quo_ff[k] <= {quo_prev[QuoWidth-2:0], ge};
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo = quo_ff[QuoWidth-1];

endmodule

FILE: src/mit_motor_frame_codec_unit.sv
// channel  | dir | handshake           | carries
// req_ch   | in  | valid/ready         | func, commands, feedback frame
// rsp_ch   | out | valid/ready         | tx frame and decoded feedback
// csr_*    | in  | write enable only   | ids and limits
//
// one transfer per cycle sustained while results are accepted; request to result runs through
// the input stage, prepare stage, 27-stage bit-per-stage divider and output register
// synchronous active-high reset clears control and registers; payload is not reset
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
module mit_motor_frame_codec_unit (
   input  logic                             clock,
   input  logic                             reset,
   mfc_req_if.sink                          req_ch,
   mfc_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [mfc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mfc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int QW = mfc_pkg::DIV_QUO_W;
   localparam int NW = mfc_pkg::DIV_NUM_W;
   localparam int DW = mfc_pkg::DIV_DEN_W;

   // configuration registers
   logic [mfc_pkg::ID_W-1:0]  base_id_ff, id_off_ff;
   logic [mfc_pkg::LIM_W-1:0] pos_lim_ff, vel_lim_ff, tq_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff <= mfc_pkg::BASE_ID_RST;
         id_off_ff  <= mfc_pkg::ID_OFFSET_RST;
         pos_lim_ff <= mfc_pkg::POS_LIM_RST;
         vel_lim_ff <= mfc_pkg::VEL_LIM_RST;
         tq_lim_ff  <= mfc_pkg::TQ_LIM_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            mfc_pkg::CSR_BASE_ID:   base_id_ff <= csr_wdata[mfc_pkg::ID_W-1:0];
            mfc_pkg::CSR_ID_OFFSET: id_off_ff  <= csr_wdata[mfc_pkg::ID_W-1:0];
            mfc_pkg::CSR_POS_LIMIT: pos_lim_ff <= csr_wdata;
            mfc_pkg::CSR_VEL_LIMIT: vel_lim_ff <= csr_wdata;
            mfc_pkg::CSR_TQ_LIMIT:  tq_lim_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [mfc_pkg::LIM_W-1:0] pos_lim, vel_lim, tq_lim;
   logic [mfc_pkg::ID_W-1:0]  tx_id;

   assign pos_lim = mfc_pkg::eff_limit(pos_lim_ff);
   assign vel_lim = mfc_pkg::eff_limit(vel_lim_ff);
   assign tq_lim  = mfc_pkg::eff_limit(tq_lim_ff);
   assign tx_id   = base_id_ff + id_off_ff;

   // global pipeline advance
   logic out_v_ff;
   logic advance;

   assign advance      = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // input stage
   logic             s1_v_ff;
   mfc_pkg::req_type s1_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (advance) s1_v_ff <= req_ch.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff.func          <= mfc_pkg::func_type'(req_ch.func);
         s1_ff.pos_cmd       <= req_ch.pos_cmd;
         s1_ff.vel_cmd       <= req_ch.vel_cmd;
         s1_ff.stiffness_cmd <= req_ch.stiffness_cmd;
         s1_ff.damping_cmd   <= req_ch.damping_cmd;
         s1_ff.torque_cmd    <= req_ch.torque_cmd;
         s1_ff.rx_frame      <= req_ch.rx_frame;
      end
   end

   // gain clamp and scale by 4095, low power-of-two part dropped
   logic [24:0] kp_c;
   logic [18:0] kd_c;
   logic [36:0] kp_w;
   logic [30:0] kd_w;

   assign kp_c = (s1_ff.stiffness_cmd > 31'(mfc_pkg::KP_TOP)) ?
                 mfc_pkg::KP_TOP : s1_ff.stiffness_cmd[24:0];
   assign kd_c = (s1_ff.damping_cmd > 31'(mfc_pkg::KD_TOP)) ?
                 mfc_pkg::KD_TOP : s1_ff.damping_cmd[18:0];
   assign kp_w = (37'(kp_c) << 12) - 37'(kp_c);
   assign kd_w = (31'(kd_c) << 12) - 31'(kd_c);

   // clamp, offset and dequant products
   mfc_pkg::prep_type s2_in, s2_ff;
   logic              s2_v_ff;

   always_comb begin
      s2_in.side.func  = s1_ff.func;
      s2_in.side.hdr   = s1_ff.rx_frame[63:56];
      s2_in.side.temps = s1_ff.rx_frame[15:0];
      // gain codes are filled in one stage later
      s2_in.side.kp_q  = '0;
      s2_in.side.kd_q  = '0;
      s2_in.u_pos      = mfc_pkg::clamp_offset(s1_ff.pos_cmd, pos_lim);
      s2_in.u_vel      = mfc_pkg::clamp_offset(s1_ff.vel_cmd, vel_lim);
      s2_in.u_tq       = mfc_pkg::clamp_offset(s1_ff.torque_cmd, tq_lim);
      s2_in.kp_z       = kp_w[36:18];
      s2_in.kd_z       = kd_w[30:16];
      s2_in.dq_pos     = 43'(s1_ff.rx_frame[55:40]) * 43'({pos_lim, 1'b0});
      s2_in.dq_vel     = 39'(s1_ff.rx_frame[39:28]) * 39'({vel_lim, 1'b0});
      s2_in.dq_tq      = 39'(s1_ff.rx_frame[27:16]) * 39'({tq_lim, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (advance) s2_v_ff <= s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) s2_ff <= s2_in;
   end

   // divider operands: quantize for commands, dequantize for feedback
   logic          dec;
   logic [NW-1:0] num_pos, num_vel, num_tq;
   logic [DW-1:0] den_pos, den_vel, den_tq;

   assign dec     = (s2_ff.side.func == mfc_pkg::FUNC_DECODE);
   assign num_pos = dec ? s2_ff.dq_pos :
                    (NW'(s2_ff.u_pos) << 16) - NW'(s2_ff.u_pos);
   assign num_vel = dec ? NW'(s2_ff.dq_vel) :
                    (NW'(s2_ff.u_vel) << 12) - NW'(s2_ff.u_vel);
   assign num_tq  = dec ? NW'(s2_ff.dq_tq) :
                    (NW'(s2_ff.u_tq) << 12) - NW'(s2_ff.u_tq);
   assign den_pos = dec ? mfc_pkg::TOP16 : {pos_lim, 1'b0};
   assign den_vel = dec ? mfc_pkg::TOP12 : {vel_lim, 1'b0};
   assign den_tq  = dec ? mfc_pkg::TOP12 : {tq_lim, 1'b0};

   logic [QW-1:0] q_pos, q_vel, q_tq;

   mfc_div #(.NumWidth(NW), .DenWidth(DW), .QuoWidth(QW)) u_div_pos (
      .clock(clock), .advance(advance), .num(num_pos), .den(den_pos), .quo(q_pos));
   mfc_div #(.NumWidth(NW), .DenWidth(DW), .QuoWidth(QW)) u_div_vel (
      .clock(clock), .advance(advance), .num(num_vel), .den(den_vel), .quo(q_vel));
   mfc_div #(.NumWidth(NW), .DenWidth(DW), .QuoWidth(QW)) u_div_tq (
      .clock(clock), .advance(advance), .num(num_tq), .den(den_tq), .quo(q_tq));

   // gain codes by reciprocal multiply, beside the first divider stage
   logic [38:0]       kp_prod;
   logic [29:0]       kd_prod;
   mfc_pkg::side_type side_s2;

   assign kp_prod = 39'(s2_ff.kp_z) * 39'(mfc_pkg::KP_RECIP);
   assign kd_prod = 30'(s2_ff.kd_z) * 30'(mfc_pkg::KD_RECIP);

   always_comb begin
      side_s2      = s2_ff.side;
      side_s2.kp_q = kp_prod[37:26];
      side_s2.kd_q = kd_prod[28:17];
   end

   // valid bits and side data alongside the dividers
   logic [QW-1:0]     dv_ff;
   mfc_pkg::side_type side_ff [QW];

   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else if (advance) dv_ff <= {dv_ff[QW-2:0], s2_v_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_s2;
         for (int i = 1; i < QW; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // result assembly
   mfc_pkg::side_type side_o;
   mfc_pkg::rsp_type  out_in, out_ff;

   assign side_o = side_ff[QW-1];

   always_comb begin
      out_in = '0;
      unique case (side_o.func)
         mfc_pkg::FUNC_CMD: begin
            out_in.tx_valid = 1'b1;
            out_in.tx_id    = tx_id;
            out_in.tx_data  = {q_pos[15:0], q_vel[11:0], side_o.kp_q,
                               side_o.kd_q, q_tq[11:0]};
         end
         mfc_pkg::FUNC_ENABLE: begin
            out_in.tx_valid = 1'b1;
            out_in.tx_id    = tx_id;
            out_in.tx_data  = mfc_pkg::FRAME_FILL | 64'(mfc_pkg::ENABLE_CODE);
         end
         mfc_pkg::FUNC_DISABLE: begin
            out_in.tx_valid = 1'b1;
            out_in.tx_id    = tx_id;
            out_in.tx_data  = mfc_pkg::FRAME_FILL | 64'(mfc_pkg::DISABLE_CODE);
         end
         mfc_pkg::FUNC_DECODE: begin
            out_in.fb_motor_id = side_o.hdr[3:0];
            out_in.fb_state    = side_o.hdr[7:4];
            out_in.fb_position = 32'(q_pos) - 32'(pos_lim);
            out_in.fb_velocity = 32'(q_vel) - 32'(vel_lim);
            out_in.fb_torque   = 32'(q_tq) - 32'(tq_lim);
            out_in.mos_temp    = side_o.temps[15:8];
            out_in.coil_temp   = side_o.temps[7:0];
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= dv_ff[QW-1];
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.tx_valid    = out_ff.tx_valid;
   assign rsp_ch.tx_id       = out_ff.tx_id;
   assign rsp_ch.tx_data     = out_ff.tx_data;
   assign rsp_ch.fb_motor_id = out_ff.fb_motor_id;
   assign rsp_ch.fb_state    = out_ff.fb_state;
   assign rsp_ch.fb_position = out_ff.fb_position;
   assign rsp_ch.fb_velocity = out_ff.fb_velocity;
   assign rsp_ch.fb_torque   = out_ff.fb_torque;
   assign rsp_ch.mos_temp    = out_ff.mos_temp;
   assign rsp_ch.coil_temp   = out_ff.coil_temp;

   // checks
   a_stall_freezes_line: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(dv_ff) && $stable(s2_v_ff) && $stable(s1_v_ff))
      else $error("pipeline valid bits moved during a stall");

   a_tx_clears_feedback: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.tx_valid |-> out_ff.fb_position == '0 &&
      out_ff.fb_velocity == '0 && out_ff.fb_torque == '0)
      else $error("transmit result carries feedback fields");

   a_decode_clears_tx: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !out_ff.tx_valid |-> out_ff.tx_data == '0 && out_ff.tx_id == '0)
      else $error("feedback result carries transmit fields");

endmodule

FILE: tb/testbench.sv
module testbench;

   localparam logic [mfc_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int PHASES    = 7;
   localparam int PHASE_LEN = 150;
   localparam int SETTLE    = 40;

   typedef struct {
      mfc_pkg::req_type req;
      bit               typed;
      mfc_pkg::rsp_type want;
   } dir_row;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [mfc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mfc_pkg::CSR_DATA_W-1:0] csr_wdata;

   mfc_req_if req_if ();
   mfc_rsp_if rsp_if ();

   mit_motor_frame_codec_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // local copy of the register file
   logic [mfc_pkg::ID_W-1:0]  base_id;
   logic [mfc_pkg::ID_W-1:0]  id_offset;
   logic [mfc_pkg::LIM_W-1:0] pos_lim;
   logic [mfc_pkg::LIM_W-1:0] vel_lim;
   logic [mfc_pkg::LIM_W-1:0] tq_lim;

   mfc_pkg::rsp_type pending_frames[$];
   int      mismatches;
   bit      failed;
   int      sent_count;
   int      burst_left;
   bit      stall_hold;
   int      rcv_tick;
   int      rcv_mode;
   dir_row  dir_rows[12];

   // clamp to +/- lim and scale onto a code of top steps
   function automatic longint code_of(logic signed [31:0] x,
                                      logic [mfc_pkg::LIM_W-1:0] lim, longint top);
      longint xs;
      longint l;
      xs = x;
      l  = (lim == '0) ? 1 : lim;
      if (xs > l) xs = l;
      if (xs < -l) xs = -l;
      return ((xs + l) * top) / (2 * l);
   endfunction

   function automatic longint gain_code(logic [30:0] x, longint top);
      longint g;
      g = x;
      if (g > top) g = top;
      return (g * 4095) / top;
   endfunction

   function automatic logic [31:0] level_of(longint q, logic [mfc_pkg::LIM_W-1:0] lim,
                                            longint top);
      longint l;
      l = (lim == '0) ? 1 : lim;
      return 32'((q * 2 * l) / top - l);
   endfunction

   function automatic mfc_pkg::rsp_type frame_result(mfc_pkg::req_type r);
      mfc_pkg::rsp_type o;
      logic [63:0] p, v, kp, kd, t;
      o = '0;
      case (r.func)
         mfc_pkg::FUNC_CMD: begin
            p  = 64'(code_of(r.pos_cmd, pos_lim, 65535));
            v  = 64'(code_of(r.vel_cmd, vel_lim, 4095));
            kp = 64'(gain_code(r.stiffness_cmd, mfc_pkg::KP_TOP));
            kd = 64'(gain_code(r.damping_cmd, mfc_pkg::KD_TOP));
            t  = 64'(code_of(r.torque_cmd, tq_lim, 4095));
            o.tx_valid = 1'b1;
            o.tx_id    = base_id + id_offset;
            o.tx_data  = (p << 48) | (v << 36) | (kp << 24) | (kd << 12) | t;
         end
         mfc_pkg::FUNC_ENABLE, mfc_pkg::FUNC_DISABLE: begin
            o.tx_valid = 1'b1;
            o.tx_id    = base_id + id_offset;
            o.tx_data  = mfc_pkg::FRAME_FILL |
                         ((r.func == mfc_pkg::FUNC_ENABLE) ? mfc_pkg::ENABLE_CODE
                                                          : mfc_pkg::DISABLE_CODE);
         end
         default: begin
            o.fb_motor_id = r.rx_frame[59:56];
            o.fb_state    = r.rx_frame[63:60];
            o.fb_position = level_of(r.rx_frame[55:40], pos_lim, 65535);
            o.fb_velocity = level_of(r.rx_frame[39:28], vel_lim, 4095);
            o.fb_torque   = level_of(r.rx_frame[27:16], tq_lim, 4095);
            o.mos_temp    = r.rx_frame[15:8];
            o.coil_temp   = r.rx_frame[7:0];
         end
      endcase
      return o;
   endfunction

   // random signed command: wild, in range, near the edge or tiny
   function automatic logic [31:0] pick_signed(logic [mfc_pkg::LIM_W-1:0] lim);
      longint l;
      l = (lim == '0) ? 1 : lim;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'(longint'($urandom_range(0, 2 * l)) - l);
         2: return 32'(($urandom_range(0, 1) ? l : -l) + $signed($urandom_range(0, 2)) - 1);
         default: return 32'($signed($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   function automatic logic [30:0] pick_gain(longint top);
      case ($urandom_range(0, 2))
         0: return 31'($urandom);
         1: return 31'($urandom_range(0, top + top / 8));
         default: return 31'(top + $signed($urandom_range(0, 2)) - 1);
      endcase
   endfunction

   function automatic mfc_pkg::req_type random_req();
      mfc_pkg::req_type r;
      r.func          = mfc_pkg::func_type'($urandom_range(0, 3));
      r.pos_cmd       = pick_signed(pos_lim);
      r.vel_cmd       = pick_signed(vel_lim);
      r.stiffness_cmd = pick_gain(mfc_pkg::KP_TOP);
      r.damping_cmd   = pick_gain(mfc_pkg::KD_TOP);
      r.torque_cmd    = pick_signed(tq_lim);
      r.rx_frame      = {$urandom, $urandom};
      return r;
   endfunction

   // offer one item in bursts with gaps, block until the transfer
   task automatic send_frame(mfc_pkg::req_type r, bit typed, mfc_pkg::rsp_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid         <= 1'b1;
      req_if.func          <= r.func;
      req_if.pos_cmd       <= r.pos_cmd;
      req_if.vel_cmd       <= r.vel_cmd;
      req_if.stiffness_cmd <= r.stiffness_cmd;
      req_if.damping_cmd   <= r.damping_cmd;
      req_if.torque_cmd    <= r.torque_cmd;
      req_if.rx_frame      <= r.rx_frame;
      do @(posedge clock); while (!req_if.ready);
      pending_frames.push_back(typed ? want : frame_result(r));
      sent_count++;
   endtask

   // wait for every result, then let the pipeline drain before a write
   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(logic [mfc_pkg::ID_W-1:0] b, logic [mfc_pkg::ID_W-1:0] o,
                             logic [mfc_pkg::LIM_W-1:0] p, logic [mfc_pkg::LIM_W-1:0] v,
                             logic [mfc_pkg::LIM_W-1:0] t);
      logic [mfc_pkg::CSR_DATA_W-1:0] vals[5];
      logic [mfc_pkg::CSR_IDX_W-1:0]  idx[5];
      vals = '{mfc_pkg::CSR_DATA_W'(b), mfc_pkg::CSR_DATA_W'(o), p, v, t};
      idx  = '{mfc_pkg::CSR_BASE_ID, mfc_pkg::CSR_ID_OFFSET, mfc_pkg::CSR_POS_LIMIT,
               mfc_pkg::CSR_VEL_LIMIT, mfc_pkg::CSR_TQ_LIMIT};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // spare index must be ignored
      csr_index <= CSR_SPARE;
      csr_wdata <= mfc_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      base_id   = b;
      id_offset = o;
      pos_lim   = p;
      vel_lim   = v;
      tq_lim    = t;
   endtask

   function automatic logic [mfc_pkg::LIM_W-1:0] random_limit();
      return $urandom_range(0, 1) ? mfc_pkg::LIM_W'($urandom_range(1, 2000))
                                  : mfc_pkg::LIM_W'($urandom_range(1, 26'h3FFFFFF));
   endfunction

   task automatic note_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         failed = 1'b1;
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      mfc_pkg::rsp_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_frames.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer");
         end else begin
            w = pending_frames.pop_front();
            note_field("tx_valid", w.tx_valid, rsp_if.tx_valid);
            note_field("tx_id", w.tx_id, rsp_if.tx_id);
            note_field("tx_data", w.tx_data, rsp_if.tx_data);
            note_field("fb_motor_id", w.fb_motor_id, rsp_if.fb_motor_id);
            note_field("fb_state", w.fb_state, rsp_if.fb_state);
            note_field("fb_position", w.fb_position, $unsigned(rsp_if.fb_position));
            note_field("fb_velocity", w.fb_velocity, $unsigned(rsp_if.fb_velocity));
            note_field("fb_torque", w.fb_torque, $unsigned(rsp_if.fb_torque));
            note_field("mos_temp", w.mos_temp, rsp_if.mos_temp);
            note_field("coil_temp", w.coil_temp, rsp_if.coil_temp);
         end
      end
   end

   // receiver stall pattern, switching among three randomly picked modes
   always @(posedge clock) begin
      rcv_tick++;
      if (rcv_tick % 64 == 0) rcv_mode = $urandom_range(0, 2);
      rsp_if.ready <= !reset && !stall_hold &&
                      (rcv_mode == 0 || $urandom_range(0, 3) < (rcv_mode == 1 ? 3 : 1));
   end

   // long hold-off so the pipeline fills and backs up the input
   initial begin
      stall_hold = 1'b0;
      wait (sent_count >= 400);
      @(posedge clock);
      stall_hold <= 1'b1;
      repeat (300) @(posedge clock);
      stall_hold <= 1'b0;
   end

   initial begin
      #2000000;
      $display("** mit_motor_frame_codec_unit: FAILED **");
      $finish;
   end

   initial begin
      mfc_pkg::rsp_type none;
      none = '0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.func = mfc_pkg::FUNC_CMD;
      req_if.pos_cmd = '0;
      req_if.vel_cmd = '0;
      req_if.stiffness_cmd = '0;
      req_if.damping_cmd = '0;
      req_if.torque_cmd = '0;
      req_if.rx_frame = '0;
      rsp_if.ready = 1'b0;
      mismatches = 0;
      failed = 1'b0;
      sent_count = 0;
      burst_left = 0;
      rcv_tick = 0;
      rcv_mode = 0;
      base_id = mfc_pkg::BASE_ID_RST;
      id_offset = mfc_pkg::ID_OFFSET_RST;
      pos_lim = mfc_pkg::POS_LIM_RST;
      vel_lim = mfc_pkg::VEL_LIM_RST;
      tq_lim = mfc_pkg::TQ_LIM_RST;

      // directed rows at reset settings
      dir_rows[0] = '{'{mfc_pkg::FUNC_ENABLE, 0, 0, 0, 0, 0, 0}, 1,
                      '{1, 1, 64'hFFFF_FFFF_FFFF_FFFC, 0, 0, 0, 0, 0, 0, 0}};
      dir_rows[1] = '{'{mfc_pkg::FUNC_DISABLE, 0, 0, 0, 0, 0, 0}, 1,
                      '{1, 1, 64'hFFFF_FFFF_FFFF_FFFD, 0, 0, 0, 0, 0, 0, 0}};
      dir_rows[2] = '{'{mfc_pkg::FUNC_CMD, 0, 0, 0, 0, 0, 0}, 1,
                      '{1, 1, 64'h7FFF_7FF0_0000_07FF, 0, 0, 0, 0, 0, 0, 0}};
      dir_rows[3] = '{'{mfc_pkg::FUNC_CMD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        31'h7FFF_FFFF, 32'h7FFF_FFFF, 0}, 1,
                      '{1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0}};
      dir_rows[4] = '{'{mfc_pkg::FUNC_CMD, 32'h8000_0000, 32'h8000_0000, 0, 0,
                        32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF}, 1,
                      '{1, 1, 64'h0, 0, 0, 0, 0, 0, 0, 0}};
      dir_rows[5] = '{'{mfc_pkg::FUNC_DECODE, 0, 0, 0, 0, 0, 0}, 1,
                      '{0, 0, 0, 0, 0, 32'hFFF3_8000, 32'hFFE2_0000, 32'hFFF6_0000, 0, 0}};
      dir_rows[6] = '{'{mfc_pkg::FUNC_DECODE, 32'h7FFF_FFFF, 1, 5, 6, 7,
                        64'hFFFF_FFFF_FFFF_FFFF}, 1,
                      '{0, 0, 0, 4'hF, 4'hF, 32'h000C_8000, 32'h001E_0000, 32'h000A_0000,
                        8'hFF, 8'hFF}};
      dir_rows[7] = '{'{mfc_pkg::FUNC_CMD, 819200, -1966080, 32768000, 327680, 655361, 0},
                      0, none};
      dir_rows[8] = '{'{mfc_pkg::FUNC_CMD, -819201, 1966081, 32768001, 327681, -655360, 0},
                      0, none};
      dir_rows[9] = '{'{mfc_pkg::FUNC_DECODE, 123, -45, 6, 7, 8, 64'h5A12_3456_789A_BCDE},
                      0, none};
      dir_rows[10] = '{'{mfc_pkg::FUNC_DISABLE, -5, 5, 99, 98, 97, 64'hA5FF_FF00_0FFF_1234},
                       0, none};
      dir_rows[11] = '{'{mfc_pkg::FUNC_CMD, 1, -1, 65536, 65536, 65535, 64'h1234}, 0, none};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_frame(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

      // settings phases: extremes first, then random
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: write_regs(11'h7FF, 11'h7FF, 26'h3FFFFFF, 26'h3FFFFFF, 26'h3FFFFFF);
            1: write_regs(11'h000, 11'h000, 26'h0, 26'h0, 26'h0);
            2: write_regs(11'd5, 11'd100, 26'd1, 26'd1, 26'd1);
            default: write_regs(mfc_pkg::ID_W'($urandom), mfc_pkg::ID_W'($urandom),
                                random_limit(), random_limit(), random_limit());
         endcase
         if (ph == 0)
            foreach (dir_rows[i]) send_frame(dir_rows[i].req, 1'b0, none);
         for (int n = 0; n < PHASE_LEN; n++) send_frame(random_req(), 1'b0, none);
      end

      drain();
      if (!failed && pending_frames.size() == 0) begin
         $display("** mit_motor_frame_codec_unit: PASSED **");
      end else begin
         $display("** mit_motor_frame_codec_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/mfc_pkg.sv
src/mfc_req_if.sv
src/mfc_rsp_if.sv
src/mfc_div.sv
src/mit_motor_frame_codec_unit.sv
tb/testbench.sv
